/* rtl/core/arct_pkg.sv */
// ----------------------------------------------------------------------------
// arct_pkg
// Shared constants, types and the arctangent step table.
// ----------------------------------------------------------------------------
`default_nettype none

package arct_pkg;

  localparam int MAX_SAMPLES  = 64;
  localparam int ADDR_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
  localparam int SX_W         = $clog2(MAX_SAMPLES * 128 + 1);
  localparam int SY_W         = $clog2(MAX_SAMPLES * 32768 + 1);
  localparam int SHAPE_W      = 16;
  localparam int MAG_W        = 15;
  localparam int GAIN_W       = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 48;
  localparam int Z_W          = 34;
  localparam int NUM_W        = SX_W + 23;
  localparam int RATIO_W      = 33;
  localparam int PROD_W       = RATIO_W + MAG_W;
  localparam int QCNT_W       = $clog2(NUM_W);

  localparam logic [GAIN_W-1:0] DRIVE_RESET = 16'd6402;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ATAN,
    S_DIVGO,
    S_DIV,
    S_RD,
    S_MUL,
    S_RND,
    S_OUT
  } state_t;

  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = 34'sd843314856;
      4'd1:    v = 34'sd497837829;
      4'd2:    v = 34'sd263043836;
      4'd3:    v = 34'sd133525158;
      4'd4:    v = 34'sd67021686;
      4'd5:    v = 34'sd33543515;
      4'd6:    v = 34'sd16775850;
      4'd7:    v = 34'sd8388437;
      4'd8:    v = 34'sd4194282;
      4'd9:    v = 34'sd2097149;
      4'd10:   v = 34'sd1048575;
      4'd11:   v = 34'sd524287;
      4'd12:   v = 34'sd262143;
      4'd13:   v = 34'sd131071;
      4'd14:   v = 34'sd65535;
      4'd15:   v = 34'sd32767;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/arctan_distortion_normalized.sv */
// ----------------------------------------------------------------------------
// arctan_distortion_normalized
// Arctangent soft-clip distortion over a block of samples, loudness matched.
// ----------------------------------------------------------------------------
// Each input item runs the 16 CORDIC steps in the shared vectoring unit
// plus accept and writeback; in_stall stays high meanwhile. The item
// that closes a block (last_in, or the 64th sample) then has the sum
// ratio formed in the bit-serial divider (skipped when the shaped sum is
// zero), followed by store read, multiply, round and output register
// for each result, the output register held while out_stall is high. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arctan_distortion_normalized (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [15:0]                  cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [7:0]            in_sample_in,
  input  wire logic                         in_last_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                out_sample_out,
  output logic                              out_last_out
);
  import arct_pkg::*;

  state_t              state_r, state_nxt;
  logic [GAIN_W-1:0]   gain_r;
  logic [CNT_W-1:0]    count_r;
  logic [SX_W-1:0]     sx_r;
  logic [SY_W-1:0]     sy_r;
  logic [ADDR_W-1:0]   k_r;
  logic                neg_r, close_r;
  logic [RATIO_W-1:0]  ratio_r;
  logic [PROD_W-1:0]   prod_r;
  logic                rneg_r;
  logic signed [15:0]  out_r;
  logic                olast_r;

  logic                accept, cord_start, cord_done, div_start, div_done, ram_we;
  logic [MAG_W-1:0]    cord_res;
  logic [NUM_W-1:0]    quot;
  logic [SHAPE_W-1:0]  ram_wdata, ram_rdata;
  logic [7:0]          in_mag;
  logic [MAG_W-1:0]    rd_mag;
  logic [PROD_W-1:0]   rnd;
  logic [PROD_W-19:0]  r;
  logic [15:0]         code;

  assign accept = in_valid && !in_stall;
  assign in_mag = in_sample_in[7] ? 8'(-in_sample_in) : 8'(in_sample_in);

  arct_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_start),
    .gain   (gain_r),
    .mag    (in_mag),
    .done   (cord_done),
    .result (cord_res)
  );

  arct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sx_r, 23'b0} + NUM_W'(sy_r >> 1)),
    .den   (sy_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign ram_wdata = neg_r ? SHAPE_W'(-{1'b0, cord_res}) : SHAPE_W'({1'b0, cord_res});

  arct_ram #(
    .WIDTH (SHAPE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ATAN;
      S_ATAN:  if (cord_done) state_nxt = close_r ? S_DIVGO : S_IDLE;
      S_DIVGO: state_nxt = (sy_r == '0) ? S_RD : S_DIV;
      S_DIV:   if (div_done) state_nxt = S_RD;
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_RND;
      S_RND:   state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = (CNT_W'(k_r) + 1'b1 == count_r) ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    cord_start = accept;
    ram_we     = (state_r == S_ATAN) && cord_done;
    div_start  = (state_r == S_DIVGO) && (sy_r != '0);
    out_valid  = (state_r == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gain_r  <= DRIVE_RESET;
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (accept) begin
        sx_r <= sx_r + SX_W'(in_mag);
      end
      if (ram_we) begin
        count_r <= count_r + 1'b1;
        sy_r    <= sy_r + SY_W'(cord_res);
      end
      if (state_r == S_OUT && !out_stall) begin
        if (CNT_W'(k_r) + 1'b1 == count_r) begin
          k_r     <= '0;
          count_r <= '0;
          sx_r    <= '0;
          sy_r    <= '0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  assign rd_mag = ram_rdata[SHAPE_W-1] ? MAG_W'(-ram_rdata) : MAG_W'(ram_rdata);
  assign rnd    = prod_r + PROD_W'(1 << 17);
  assign r      = rnd[PROD_W-1:18];

  always_comb begin
    if (rneg_r) begin
      code = (r > 30'd32768) ? 16'h8000 : 16'(-r[15:0]);
    end else begin
      code = (r > 30'd32767) ? 16'h7fff : r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r   <= in_sample_in[7];
      close_r <= in_last_in || (count_r + 1'b1 == CNT_W'(MAX_SAMPLES));
    end
    if (state_r == S_DIVGO && sy_r == '0) begin
      ratio_r <= '0;
    end
    if (div_done) begin
      ratio_r <= (quot[NUM_W-1:RATIO_W] != '0) ? '1 : quot[RATIO_W-1:0];
    end
    if (state_r == S_MUL) begin
      prod_r <= ratio_r * rd_mag;
      rneg_r <= ram_rdata[SHAPE_W-1];
    end
    if (state_r == S_RND) begin
      out_r   <= signed'(code);
      olast_r <= (CNT_W'(k_r) + 1'b1 == count_r);
    end
  end

  assign out_sample_out = out_r;
  assign out_last_out   = olast_r;

endmodule

`default_nettype wire

/* rtl/core/arct_ram.sv */
// ----------------------------------------------------------------------------
// arct_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module arct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/arct_cordic.sv */
// ----------------------------------------------------------------------------
// arct_cordic
// Vectoring CORDIC, one step per cycle: atan(gain*mag/2048) in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module arct_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [arct_pkg::GAIN_W-1:0]   gain,
  input  wire logic [7:0]                    mag,
  output logic                               done,
  output logic      [arct_pkg::MAG_W-1:0]    result
);
  import arct_pkg::*;

  logic signed [XY_W-1:0]   x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [Z_W-1:0]    z_r, z_nxt, zc;
  logic [STEP_W-1:0]        i_r;
  logic                     busy_r, zero_r, done_r;
  logic [GAIN_W+7:0]        prod;
  logic [Z_W-1:0]           zr;
  logic [MAG_W-1:0]         res_r;

  assign prod = gain * {{(GAIN_W){1'b0}}, mag};
  assign dx   = y_r >>> i_r;
  assign dy   = x_r >>> i_r;

  always_comb begin
    if (!y_r[XY_W-1]) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_step(i_r);
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_step(i_r);
    end
  end

  assign zc = z_nxt[Z_W-1] ? '0 : z_nxt;
  assign zr = (zc + 34'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= XY_W'(64'sd1 <<< 31);
      y_r    <= signed'({4'b0, prod, 20'b0});
      z_r    <= '0;
      i_r    <= '0;
      zero_r <= (prod == '0);
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 1'b1;
      if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        res_r <= zero_r ? '0 : zr[MAG_W-1:0];
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

/* rtl/core/arct_div.sv */
// ----------------------------------------------------------------------------
// arct_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arct_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [arct_pkg::NUM_W-1:0]    num,
  input  wire logic [arct_pkg::SY_W-1:0]     den,
  output logic                               done,
  output logic      [arct_pkg::NUM_W-1:0]    quot
);
  import arct_pkg::*;

  logic [NUM_W-1:0]  q_r;
  logic [SY_W-1:0]   den_r;
  logic [SY_W-1:0]   rem_r;
  logic [SY_W:0]     trial;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;

  assign trial = {rem_r, q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == QCNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_r <= SY_W'(trial - {1'b0, den_r});
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[SY_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

/* bench/arctan_distortion_normalized_chk.sv */
// ----------------------------------------------------------------------------
// arctan_distortion_normalized_chk
// Watches the sample and result channels and predicts every result.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the block state and the gain register. For
// each accepted item it runs the CORDIC shaping. When an item closes a block,
// it queues the normalized results. Each result that the receiver takes is
// compared with the oldest queued result.
// ----------------------------------------------------------------------------
module arctan_distortion_normalized_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [7:0]  in_sample_in,
  input  logic               in_last_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_sample_out,
  input  logic               out_last_out,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } shaped_result_t;

  localparam longint ATAN_LUT [16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  shaped_result_t     expected_q[$];
  logic [15:0]        gain;
  logic signed [15:0] shaped_mem [arct_pkg::MAX_SAMPLES];
  int                 fill;
  longint unsigned    mag_sum;
  longint unsigned    shaped_sum;

  function automatic longint atan_q14(logic [15:0] g, longint m);
    longint x, y, z, dx, dy;
    x = 64'sd1 <<< 31;
    y = longint'(g) * m * (64'sd1 <<< 20);
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end
    end
    if (z < 0) z = 0;
    return (z + 32768) >>> 16;
  endfunction

  always @(posedge clk) begin
    longint          m, a, r;
    longint unsigned ratio;
    shaped_result_t  got, want;
    if (!rst_n) begin
      gain = arct_pkg::DRIVE_RESET;
      fill = 0;
      mag_sum = 0;
      shaped_sum = 0;
      fail_count = 0;
      result_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) gain = cfg_wdata;
      if (out_valid && !out_stall) begin
        got.sample = out_sample_out;
        got.last = out_last_out;
        result_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item sample=%0d last=%0b", $time, got.sample,
                   got.last);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch expected sample=%0d last=%0b, actual sample=%0d last=%0b",
                     $time, want.sample, want.last, got.sample, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        m = in_sample_in < 0 ? -longint'(in_sample_in) : longint'(in_sample_in);
        a = atan_q14(gain, m);
        shaped_mem[fill] = in_sample_in < 0 ? -a : a;
        fill++;
        mag_sum += m;
        shaped_sum += a;
        if (in_last_in || fill == arct_pkg::MAX_SAMPLES) begin
          ratio = 0;
          if (shaped_sum != 0) ratio = ((mag_sum << 23) + shaped_sum / 2) / shaped_sum;
          for (int k = 0; k < fill; k++) begin
            a = shaped_mem[k];
            m = a < 0 ? -a : a;
            r = 0;
            if (shaped_sum != 0) r = longint'((ratio * m + (64'd1 << 17)) >> 18);
            if (a < 0) begin
              if (r > 32768) r = 32768;
              want.sample = 16'(-r);
            end else begin
              if (r > 32767) r = 32767;
              want.sample = 16'(r);
            end
            want.last = (k + 1 == fill);
            expected_q.push_back(want);
          end
          fill = 0;
          mag_sum = 0;
          shaped_sum = 0;
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* bench/arctan_distortion_normalized_tb.sv */
// ----------------------------------------------------------------------------
// arctan_distortion_normalized_tb
// Stimulus and verdict for the arctangent distortion block.
// ----------------------------------------------------------------------------
// Blocks of samples are sent under several drive gains, the extremes among
// them, with random gaps and stalls on both channels. The checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module arctan_distortion_normalized_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [7:0]  in_sample_in = '0;
  logic               in_last_in = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample_out;
  logic               out_last_out;
  int                 fail_count, pending, result_count;
  int                 cycles = 0;
  int                 sent = 0;
  int                 blocks = 0;
  bit                 quiet_rx = 1'b0;

  arctan_distortion_normalized i_dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_sample_in,
    .in_last_in, .out_valid, .out_stall, .out_sample_out, .out_last_out
  );

  arctan_distortion_normalized_chk i_chk (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_sample_in,
    .in_last_in, .out_valid, .out_stall, .out_sample_out, .out_last_out,
    .fail_count, .pending, .result_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    int n;
    if (quiet_rx || !out_stall) begin
      n = quiet_rx ? 0 : gap_len();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_sample(logic signed [7:0] s, logic l);
    repeat (gap_len()) @(negedge clk);
    in_valid = 1'b1;
    in_sample_in = s;
    in_last_in = l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    sent++;
  endtask

  task automatic drain_and_write(logic [15:0] g);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = g;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_block();
    int n, p;
    bit closed_by_last, zeros;
    p = $urandom_range(99);
    if (p < 70) n = $urandom_range(1, 8);
    else if (p < 94) n = $urandom_range(9, 32);
    else n = arct_pkg::MAX_SAMPLES;
    closed_by_last = (n != arct_pkg::MAX_SAMPLES) || $urandom_range(1);
    zeros = ($urandom_range(19) == 0);
    for (int i = 0; i < n; i++)
      send_sample(zeros ? 8'sd0 : 8'($urandom), (i == n - 1) && closed_by_last);
    blocks++;
  endtask

  initial begin
    logic [15:0] gains [7];
    gains = '{16'd6402, 16'd0, 16'hFFFF, 16'd1, 16'd16, 16'($urandom), 16'($urandom)};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_sample(8'sd127, 1'b0);
    send_sample(-8'sd128, 1'b0);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd1, 1'b0);
    send_sample(-8'sd1, 1'b1);
    send_sample(8'sd0, 1'b1);
    send_sample(-8'sd128, 1'b1);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd0, 1'b1);
    blocks += 4;

    for (int ph = 0; ph < 7; ph++) begin
      drain_and_write(gains[ph]);
      quiet_rx = (ph == 3);
      while (sent < 9 + (ph + 1) * 52) random_block();
    end
    quiet_rx = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d samples in %0d blocks, checked %0d results over 7 gain settings",
             sent, blocks, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
